>>> src/lattice_boundary_force_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lattice boundary force accumulator
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_BOUNDARY_FORCE_ACCUMULATOR_MACROS_SVH
`define LATTICE_BOUNDARY_FORCE_ACCUMULATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define LBFA_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define LBFA_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lbfa_pkg.sv
// ----------------------------------------------------------------------------
// lbfa_pkg
// Shared widths and constants of the boundary force accumulator.
// ----------------------------------------------------------------------------
package lbfa_pkg;

    // Distribution values, signed Q1.15
    localparam int PDF_W   = 16;
    // Density in Q.15: 1.0 plus nine deviations
    localparam int DENS_W  = 20;
    // Magnitude of a nonzero density
    localparam int DIV_W   = 19;
    // Reciprocal of density, signed Q16.16
    localparam int INV_W   = 32;
    // Scale register, unsigned Q8.16
    localparam int SCALE_W = 24;
    // Force sums, signed Q16.32
    localparam int SUM_W   = 48;
    // Output coefficients, signed Q16.16
    localparam int COEF_W  = 32;

    localparam logic signed [INV_W-1:0] INV_MAX     = 32'sh7FFF_FFFF;
    localparam logic [SCALE_W-1:0]      SCALE_RESET = 24'd65536;

endpackage

>>> src/lbfa_recip.sv
// ----------------------------------------------------------------------------
// lbfa_recip
// Rounded reciprocal of density, 2^31 / r in signed Q16.16, by restoring
// division at two quotient bits per cycle.
// ----------------------------------------------------------------------------
module lbfa_recip (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lbfa_pkg::DENS_W-1:0]  dens,
    output logic                                done,
    output logic signed [lbfa_pkg::INV_W-1:0]   inv
);
    import lbfa_pkg::*;

    localparam int ITER  = INV_W / 2;
    localparam int CNT_W = $clog2(ITER);

    typedef enum logic [1:0] {R_IDLE, R_RUN, R_FIN} rstate_t;

    rstate_t                   state_reg;
    logic [DIV_W-1:0]          div_reg;
    logic [DIV_W-1:0]          rem_reg;
    logic [INV_W-1:0]          quo_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      done_reg;
    logic signed [INV_W-1:0]   inv_reg;

    logic [DENS_W-1:0]         dens_abs;
    logic [INV_W-1:0]          dividend;
    logic [DIV_W:0]            rem1_w;
    logic [DIV_W:0]            rem2_w;
    logic                      ge1;
    logic                      ge2;
    logic [DIV_W:0]            rem1;
    logic [DIV_W:0]            rem2;

    // Magnitude of density and the rounded dividend 2^31 + m/2
    always_comb
    begin
        dens_abs = dens[DENS_W-1] ? (DENS_W'(0) - dens) : dens;
        dividend = (INV_W'(1) << (INV_W - 1)) + INV_W'(dens_abs[DIV_W-1:1]);
    end

    // Two restoring steps per cycle, dividend shifts out as quotient shifts in
    always_comb
    begin
        rem1_w = {rem_reg, quo_reg[INV_W-1]};
        ge1    = (rem1_w >= {1'b0, div_reg});
        rem1   = ge1 ? (rem1_w - {1'b0, div_reg}) : rem1_w;
        rem2_w = {rem1[DIV_W-1:0], quo_reg[INV_W-2]};
        ge2    = (rem2_w >= {1'b0, div_reg});
        rem2   = ge2 ? (rem2_w - {1'b0, div_reg}) : rem2_w;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            div_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            inv_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        if (dens == '0)
                        begin
                            // zero density: take the largest positive value
                            inv_reg  <= INV_MAX;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            div_reg   <= dens_abs[DIV_W-1:0];
                            neg_reg   <= dens[DENS_W-1];
                            rem_reg   <= '0;
                            quo_reg   <= dividend;
                            cnt_reg   <= '0;
                            state_reg <= R_RUN;
                        end
                    end
                end
                R_RUN:
                begin
                    rem_reg <= rem2[DIV_W-1:0];
                    quo_reg <= {quo_reg[INV_W-3:0], ge1, ge2};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(ITER - 1))
                    begin
                        state_reg <= R_FIN;
                    end
                end
                R_FIN:
                begin
                    // clip 2^31 on the positive side, apply sign otherwise
                    if (!neg_reg)
                    begin
                        inv_reg <= quo_reg[INV_W-1] ? INV_MAX : quo_reg;
                    end
                    else
                    begin
                        inv_reg <= INV_W'(0) - quo_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= R_IDLE;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign inv  = inv_reg;

endmodule

>>> src/lattice_boundary_force_accumulator.sv
// ----------------------------------------------------------------------------
// lattice_boundary_force_accumulator
// Momentum exchange force sums over the boundary cells of a D2Q9 lattice,
// reported as drag and lift coefficients at the last cell of a time step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one boundary fluid cell per
//   transfer: nine distribution deviations, the obstacle link mask and the
//   last-cell flag. Output channel (out_valid/out_ready) carries one result
//   per last cell: drag, lift and the clip flag.
//   Sequence: after its transfer a cell starts the radix-4 reciprocal
//   divider, then runs its eight links through the shared multiplier. A
//   last cell then scales both sums on the same multiplier and loads the
//   output register. in_ready is high only when the sequencer is idle, so
//   a new cell is taken only after the previous one is through the sequencer.
//   Reset clears both force sums, the output register and the sequencer and
//   loads the scale register with 1.0. The scale register is written through
//   cfg_wr_en/cfg_wr_data at any clock edge.
//   Receiver stall: the result waits in the output register; further cells
//   are still taken, and the block holds only when a new result is ready
//   while the previous one has not been transferred.
// ----------------------------------------------------------------------------
`include "lattice_boundary_force_accumulator_macros.svh"

module lattice_boundary_force_accumulator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [lbfa_pkg::SCALE_W-1:0]          cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_center,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_north,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_south,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_west,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_east,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_northwest,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_northeast,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_southwest,
    input  logic signed [lbfa_pkg::PDF_W-1:0]     pdf_southeast,
    input  logic [7:0]                            link_mask,
    input  logic                                  last_cell,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lbfa_pkg::COEF_W-1:0]    drag_coef,
    output logic signed [lbfa_pkg::COEF_W-1:0]    lift_coef,
    output logic                                  saturated
);
    import lbfa_pkg::*;

    localparam int LINK_N     = 8;
    localparam int LINK_IDX_W = $clog2(LINK_N);
    localparam int LINK_CNT_W = $clog2(LINK_N + 1);
    localparam int TERM_W     = SUM_W + 1;
    localparam int ACC_W      = SUM_W + 2;
    localparam int HALF_W     = SUM_W / 2;
    localparam int MUL_A_W    = HALF_W + 1;
    localparam int MUL_B_W    = INV_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int LO_W       = SUM_W + 1 - HALF_W;
    localparam int MAG_W      = SUM_W + 1 - 8;

    typedef enum logic [3:0] {
        S_IDLE, S_RSTART, S_RWAIT, S_LINK, S_ABS, S_XLO, S_XHI,
        S_YLO, S_YHI, S_YMAG, S_YSAT, S_EMIT
    } state_t;

    typedef enum logic [1:0] {DIR_ZERO, DIR_POS, DIR_NEG} dir_t;

    typedef struct packed {
        logic [COEF_W-1:0] val;
        logic              clip;
    } coef_t;

    // x component of each moving direction, N..SE
    function automatic dir_t link_cx(input logic [LINK_IDX_W-1:0] k);
        dir_t d;
        unique case (k)
            3'd0, 3'd1: d = DIR_ZERO;
            3'd2, 3'd4, 3'd6: d = DIR_NEG;
            3'd3, 3'd5, 3'd7: d = DIR_POS;
            default: d = DIR_ZERO;
        endcase
        return d;
    endfunction

    // y component of each moving direction, N..SE
    function automatic dir_t link_cy(input logic [LINK_IDX_W-1:0] k);
        dir_t d;
        unique case (k)
            3'd0, 3'd4, 3'd5: d = DIR_POS;
            3'd1, 3'd6, 3'd7: d = DIR_NEG;
            3'd2, 3'd3: d = DIR_ZERO;
            default: d = DIR_ZERO;
        endcase
        return d;
    endfunction

    // Add or subtract a link term, saturating to the sum range
    function automatic logic signed [SUM_W-1:0] sat_acc(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [TERM_W-1:0] t,
        input dir_t                     d
    );
        logic signed [ACC_W-1:0] ws;
        logic signed [ACC_W-1:0] wt;
        logic signed [ACC_W-1:0] r;
        logic signed [SUM_W-1:0] res;
        ws = ACC_W'(s);
        wt = ACC_W'(t);
        unique case (d)
            DIR_POS: r = ws + wt;
            DIR_NEG: r = ws - wt;
            default: r = ws;
        endcase
        if (r[ACC_W-1] && !(&r[ACC_W-2:SUM_W-1]))
        begin
            res = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else if (!r[ACC_W-1] && (|r[ACC_W-2:SUM_W-1]))
        begin
            res = {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            res = r[SUM_W-1:0];
        end
        return res;
    endfunction

    // Clip a rounded magnitude to Q16.16 and apply its sign
    function automatic coef_t sat_coef(input logic [MAG_W-1:0] m, input logic neg);
        coef_t c;
        c.clip = 1'b0;
        if (!neg)
        begin
            if (m > MAG_W'(32'h7FFF_FFFF))
            begin
                c.clip = 1'b1;
                c.val  = 32'h7FFF_FFFF;
            end
            else
            begin
                c.val = m[COEF_W-1:0];
            end
        end
        else
        begin
            if (m > MAG_W'(32'h8000_0000))
            begin
                c.clip = 1'b1;
                c.val  = 32'h8000_0000;
            end
            else
            begin
                c.val = COEF_W'(0) - m[COEF_W-1:0];
            end
        end
        return c;
    endfunction

    state_t                     state_reg;
    logic [LINK_CNT_W-1:0]      link_cnt_reg;
    logic [SCALE_W-1:0]         scale_reg;

    logic signed [PDF_W-1:0]    pdf_reg [LINK_N];
    logic [LINK_N-1:0]          mask_reg;
    logic                       last_reg;
    logic signed [DENS_W-1:0]   dens_reg;
    logic signed [DENS_W-1:0]   dens_calc;

    logic                       recip_start;
    logic                       recip_done;
    logic signed [INV_W-1:0]    recip_inv;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_vld_reg;
    logic [LINK_IDX_W-1:0]      prod_link_reg;
    logic signed [TERM_W-1:0]   term;

    logic signed [SUM_W-1:0]    sum_x_reg;
    logic signed [SUM_W-1:0]    sum_y_reg;
    logic                       sum_clr;

    logic [SUM_W-1:0]           mx_reg;
    logic [SUM_W-1:0]           my_reg;
    logic                       negx_reg;
    logic                       negy_reg;
    logic [LO_W-1:0]            lo_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [SUM_W:0]             lo_sum;
    logic [SUM_W:0]             hi_sum;
    coef_t                      coef_calc;
    logic signed [COEF_W-1:0]   drag_res_reg;
    logic signed [COEF_W-1:0]   lift_res_reg;
    logic                       clip_reg;

    logic                       out_valid_reg;
    logic signed [COEF_W-1:0]   drag_coef_reg;
    logic signed [COEF_W-1:0]   lift_coef_reg;
    logic                       saturated_reg;
    logic                       emit_go;
    logic                       in_fire;
    logic                       link_issue;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign recip_start = (state_reg == S_RSTART);
    assign emit_go     = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign sum_clr     = emit_go;
    assign link_issue  = (state_reg == S_LINK) && (link_cnt_reg != LINK_CNT_W'(LINK_N));

    // Density as 1.0 plus the nine deviations
    always_comb
    begin
        dens_calc = DENS_W'(32768) + DENS_W'(pdf_center)
                  + DENS_W'(pdf_north) + DENS_W'(pdf_south)
                  + DENS_W'(pdf_west) + DENS_W'(pdf_east)
                  + DENS_W'(pdf_northwest) + DENS_W'(pdf_northeast)
                  + DENS_W'(pdf_southwest) + DENS_W'(pdf_southeast);
    end

    // Capture the cell on transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pdf_reg[0] <= pdf_north;
            pdf_reg[1] <= pdf_south;
            pdf_reg[2] <= pdf_west;
            pdf_reg[3] <= pdf_east;
            pdf_reg[4] <= pdf_northwest;
            pdf_reg[5] <= pdf_northeast;
            pdf_reg[6] <= pdf_southwest;
            pdf_reg[7] <= pdf_southeast;
            mask_reg   <= link_mask;
            last_reg   <= last_cell;
            dens_reg   <= dens_calc;
        end
    end

    // Scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= cfg_wr_data;
        end
    end

    lbfa_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (recip_start),
        .dens  (dens_reg),
        .done  (recip_done),
        .inv   (recip_inv)
    );

    // Shared multiplier operand select: link terms, then the scaling halves
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (link_issue)
        begin
            mul_a = MUL_A_W'(pdf_reg[link_cnt_reg[LINK_IDX_W-1:0]]);
            mul_b = MUL_B_W'(recip_inv);
        end
        else
        begin
            unique case (state_reg)
                S_XLO: mul_a = MUL_A_W'({1'b0, mx_reg[HALF_W-1:0]});
                S_XHI: mul_a = MUL_A_W'({1'b0, mx_reg[SUM_W-1:HALF_W]});
                S_YLO: mul_a = MUL_A_W'({1'b0, my_reg[HALF_W-1:0]});
                S_YHI: mul_a = MUL_A_W'({1'b0, my_reg[SUM_W-1:HALF_W]});
                default: mul_a = '0;
            endcase
            mul_b = MUL_B_W'({1'b0, scale_reg});
        end
    end

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Tag products that belong to a masked link
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            prod_link_reg <= '0;
        end
        else
        begin
            prod_vld_reg  <= link_issue && mask_reg[link_cnt_reg[LINK_IDX_W-1:0]];
            prod_link_reg <= link_cnt_reg[LINK_IDX_W-1:0];
        end
    end

    // Link term 2*f*rho_inv in Q16.32
    assign term = {prod_reg[SUM_W-1:0], 1'b0};

    // Force sums: accumulate link terms, clear once the result is out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (sum_clr)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            sum_x_reg <= sat_acc(sum_x_reg, term, link_cx(prod_link_reg));
            sum_y_reg <= sat_acc(sum_y_reg, term, link_cy(prod_link_reg));
        end
    end

    // Rounding of magnitude * scale / 2^32 from two partial products
    always_comb
    begin
        lo_sum    = {1'b0, prod_reg[SUM_W-1:0]} + ((SUM_W+1)'(1) << 31);
        hi_sum    = {1'b0, prod_reg[SUM_W-1:0]} + (SUM_W+1)'(lo_reg);
        coef_calc = sat_coef(mag_reg, (state_reg == S_YHI) ? negx_reg : negy_reg);
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            link_cnt_reg  <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            negx_reg      <= 1'b0;
            negy_reg      <= 1'b0;
            lo_reg        <= '0;
            mag_reg       <= '0;
            drag_res_reg  <= '0;
            lift_res_reg  <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            drag_coef_reg <= '0;
            lift_coef_reg <= '0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            // drop the result once the receiver takes it, unless a new one loads
            if (out_valid_reg && out_ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_RSTART;
                    end
                end
                S_RSTART:
                begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (recip_done)
                    begin
                        link_cnt_reg <= '0;
                        state_reg    <= S_LINK;
                    end
                end
                S_LINK:
                begin
                    link_cnt_reg <= link_cnt_reg + LINK_CNT_W'(1);
                    if (link_cnt_reg == LINK_CNT_W'(LINK_N))
                    begin
                        state_reg <= last_reg ? S_ABS : S_IDLE;
                    end
                end
                S_ABS:
                begin
                    negx_reg  <= sum_x_reg[SUM_W-1];
                    negy_reg  <= sum_y_reg[SUM_W-1];
                    mx_reg    <= sum_x_reg[SUM_W-1] ? (SUM_W'(0) - sum_x_reg) : sum_x_reg;
                    my_reg    <= sum_y_reg[SUM_W-1] ? (SUM_W'(0) - sum_y_reg) : sum_y_reg;
                    state_reg <= S_XLO;
                end
                S_XLO:
                begin
                    state_reg <= S_XHI;
                end
                S_XHI:
                begin
                    lo_reg    <= lo_sum[SUM_W:HALF_W];
                    state_reg <= S_YLO;
                end
                S_YLO:
                begin
                    mag_reg   <= hi_sum[SUM_W:8];
                    state_reg <= S_YHI;
                end
                S_YHI:
                begin
                    lo_reg       <= lo_sum[SUM_W:HALF_W];
                    drag_res_reg <= coef_calc.val;
                    clip_reg     <= coef_calc.clip;
                    state_reg    <= S_YMAG;
                end
                S_YMAG:
                begin
                    mag_reg   <= hi_sum[SUM_W:8];
                    state_reg <= S_YSAT;
                end
                S_YSAT:
                begin
                    lift_res_reg <= coef_calc.val;
                    clip_reg     <= clip_reg | coef_calc.clip;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        drag_coef_reg <= drag_res_reg;
                        lift_coef_reg <= lift_res_reg;
                        saturated_reg <= clip_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign drag_coef = drag_coef_reg;
    assign lift_coef = lift_coef_reg;
    assign saturated = saturated_reg;

    // Checks
    `LBFA_ASSERT_IMP(a_recip_done_wait, clk, rst_n, recip_done, state_reg == S_RWAIT,
        "reciprocal finished outside its wait state")
    `LBFA_ASSERT_IMP(a_out_from_emit, clk, rst_n, $rose(out_valid), $past(state_reg == S_EMIT),
        "result presented without an emit step")
    `LBFA_ASSERT_IMP(a_busy_on_product, clk, rst_n, prod_vld_reg, !in_ready,
        "new cell accepted while a link term is pending")
    `LBFA_ASSERT_NXT(a_sums_cleared, clk, rst_n, sum_clr, (sum_x_reg == '0) && (sum_y_reg == '0),
        "force sums not cleared after a result")

endmodule

>>> tb/lattice_boundary_force_accumulator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lattice_boundary_force_accumulator_test
// Streams boundary cells into the force accumulator and checks every drag,
// lift and clip result against an in-bench fixed-point predictor. A short
// directed set is followed by random phases under several scale settings.
// Both handshakes stall at random; the last phase runs without stalls.
// ----------------------------------------------------------------------------

// One boundary cell as it crosses the input channel
typedef struct packed {
    logic [8:0][15:0] pdf;      // 0 = rest, 1..8 = N S W E NW NE SW SE
    logic [7:0]       mask;
    logic             last;
} cell_t;

// One coefficient result as it crosses the output channel
typedef struct packed {
    logic [31:0] drag;
    logic [31:0] lift;
    logic        sat;
} coef_t;

// Link directions by sign of their x and y components (bit k = mask bit k)
localparam logic [7:0] X_POS = 8'b1010_1000;
localparam logic [7:0] X_NEG = 8'b0101_0100;
localparam logic [7:0] Y_POS = 8'b0011_0001;
localparam logic [7:0] Y_NEG = 8'b1100_0010;

localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
localparam longint SUM_MIN = -SUM_MAX - 1;

// Momentum sums per time step and the coefficients they are expected to give
class coef_tracker;
    logic [lbfa_pkg::SCALE_W-1:0] scale;
    longint x_sum;
    longint y_sum;
    coef_t  pending[$];
    int     errors;
    int     cells;
    int     results;

    function new();
        scale   = lbfa_pkg::SCALE_RESET;
        x_sum   = 0;
        y_sum   = 0;
        errors  = 0;
        cells   = 0;
        results = 0;
    endfunction

    function void set_scale(logic [lbfa_pkg::SCALE_W-1:0] v);
        scale = v;
    endfunction

    function longint sat48(longint v);
        if (v > SUM_MAX)
            return SUM_MAX;
        if (v < SUM_MIN)
            return SUM_MIN;
        return v;
    endfunction

    // Q16.32 sum times Q8.16 scale, rounded to Q16.16; bit 32 flags a clip
    function logic [32:0] scale_sum(longint s);
        logic        neg;
        longint      m;
        logic [95:0] wide;
        logic [63:0] mag;
        logic        clip;
        neg  = (s < 0);
        m    = neg ? -s : s;
        wide = 96'(m) * 96'(scale) + (96'd1 << 31);
        mag  = wide[95:32];
        clip = 1'b0;
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
                clip = 1'b1;
                mag  = 64'h7FFF_FFFF;
            end
            return {clip, mag[31:0]};
        end
        if (mag > 64'h8000_0000) begin
            clip = 1'b1;
            mag  = 64'h8000_0000;
        end
        return {clip, 32'd0 - mag[31:0]};
    endfunction

    // Accumulate one accepted cell; queue a result on the last cell
    function void note_cell(cell_t c);
        int          dens;
        longint      inv;
        longint      m;
        longint      q;
        longint      f;
        longint      term;
        logic [32:0] xs;
        logic [32:0] ys;
        coef_t       res;
        cells++;
        dens = 32768;
        for (int k = 0; k < 9; k++)
            dens += int'($signed(c.pdf[k]));
        // reciprocal of density, Q16.16, round half away from zero
        if (dens == 0)
            inv = 64'sd2147483647;
        else
        begin
            m = (dens > 0) ? longint'(dens) : -longint'(dens);
            q = ((longint'(1) << 31) + m / 2) / m;
            if (dens > 0)
                inv = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
            else
                inv = (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
        end
        // add the fluid-side term of every obstacle link
        for (int k = 0; k < 8; k++)
        begin
            if (c.mask[k])
            begin
                f    = $signed(c.pdf[k + 1]);
                term = 2 * f * inv;
                if (X_POS[k])
                    x_sum = sat48(x_sum + term);
                if (X_NEG[k])
                    x_sum = sat48(x_sum - term);
                if (Y_POS[k])
                    y_sum = sat48(y_sum + term);
                if (Y_NEG[k])
                    y_sum = sat48(y_sum - term);
            end
        end
        if (c.last)
        begin
            xs       = scale_sum(x_sum);
            ys       = scale_sum(y_sum);
            res.drag = xs[31:0];
            res.lift = ys[31:0];
            res.sat  = xs[32] | ys[32];
            pending  = {pending, res};
            x_sum = 0;
            y_sum = 0;
        end
    endfunction

    // Compare one transferred result with the oldest expectation
    function void check_result(logic [31:0] drag, logic [31:0] lift, logic sat);
        coef_t exp_res;
        if (pending.size() == 0)
        begin
            $error("unexpected result: drag_coef %0d lift_coef %0d saturated %0b",
                   $signed(drag), $signed(lift), sat);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        results++;
        if (exp_res.drag !== drag)
        begin
            $error("drag_coef mismatch: expected %0d, actual %0d",
                   $signed(exp_res.drag), $signed(drag));
            errors++;
        end
        if (exp_res.lift !== lift)
        begin
            $error("lift_coef mismatch: expected %0d, actual %0d",
                   $signed(exp_res.lift), $signed(lift));
            errors++;
        end
        if (exp_res.sat !== sat)
        begin
            $error("saturated mismatch: expected %0b, actual %0b", exp_res.sat, sat);
            errors++;
        end
    endfunction
endclass

module lattice_boundary_force_accumulator_test;

    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_wr_en;
    logic [lbfa_pkg::SCALE_W-1:0]          cfg_wr_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_center;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_north;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_south;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_west;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_east;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_northwest;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_northeast;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_southwest;
    logic signed [lbfa_pkg::PDF_W-1:0]     pdf_southeast;
    logic [7:0]                            link_mask;
    logic                                  last_cell;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [lbfa_pkg::COEF_W-1:0]    drag_coef;
    logic signed [lbfa_pkg::COEF_W-1:0]    lift_coef;
    logic                                  saturated;

    coef_tracker board;
    bit          calm = 1'b0;
    int          quiet_cycles = 0;
    int          scale_writes = 0;

    lattice_boundary_force_accumulator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pdf_center    (pdf_center),
        .pdf_north     (pdf_north),
        .pdf_south     (pdf_south),
        .pdf_west      (pdf_west),
        .pdf_east      (pdf_east),
        .pdf_northwest (pdf_northwest),
        .pdf_northeast (pdf_northeast),
        .pdf_southwest (pdf_southwest),
        .pdf_southeast (pdf_southeast),
        .link_mask     (link_mask),
        .last_cell     (last_cell),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drag_coef     (drag_coef),
        .lift_coef     (lift_coef),
        .saturated     (saturated)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Record every transfer on both channels and count quiet cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(drag_coef, lift_coef, saturated);
            if (in_valid && in_ready)
                board.note_cell(cell_t'({pdf_southeast, pdf_southwest, pdf_northeast,
                                         pdf_northwest, pdf_east, pdf_west, pdf_south,
                                         pdf_north, pdf_center, link_mask, last_cell}));
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // End the run when nothing has moved for too long
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog expired after %0d cycles without a transfer", quiet_cycles);
        $display("lattice_boundary_force_accumulator_test: FAIL");
        $finish;
    end

    // Receiver: ready runs with random stall bursts, none when calm
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(40, 120)) @(negedge clk);
            else
                repeat ($urandom_range(0, 23)) @(negedge clk);
            if (!calm)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    // Present one cell after an optional idle burst; hold until transfer
    task automatic send_cell(input cell_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        pdf_center    <= c.pdf[0];
        pdf_north     <= c.pdf[1];
        pdf_south     <= c.pdf[2];
        pdf_west      <= c.pdf[3];
        pdf_east      <= c.pdf[4];
        pdf_northwest <= c.pdf[5];
        pdf_northeast <= c.pdf[6];
        pdf_southwest <= c.pdf[7];
        pdf_southeast <= c.pdf[8];
        link_mask     <= c.mask;
        last_cell     <= c.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every expected result, then let the block go idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [lbfa_pkg::SCALE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.set_scale(v);
        scale_writes++;
    endtask

    // Random cell: mostly physical deviations, some near-zero density, some raw
    function automatic cell_t random_cell();
        cell_t c;
        int    mode;
        int    sum8;
        int    v;
        mode = $urandom_range(0, 9);
        sum8 = 0;
        for (int k = 0; k < 9; k++)
        begin
            if (mode <= 4)
                v = int'($urandom_range(0, 4095)) - 2048;
            else if (mode <= 6)
                v = int'($urandom_range(0, 65535)) - 32768;
            else if (mode <= 8)
                v = int'($urandom_range(0, 16383)) - 8192;
            else
            begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            c.pdf[k] = 16'(v);
            if (k > 0)
                sum8 += v;
        end
        // steer density to a few counts around zero
        if (mode == 7 || mode == 8)
        begin
            v = -32768 - sum8 + int'($urandom_range(0, 6)) - 3;
            if (v >= -32768 && v <= 32767)
                c.pdf[0] = 16'(v);
        end
        case ($urandom_range(0, 7))
            0: c.mask = 8'h00;
            1: c.mask = 8'hFF;
            default: c.mask = 8'($urandom_range(0, 255));
        endcase
        c.last = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    task automatic run_phase(input int count);
        cell_t c;
        for (int i = 0; i < count; i++)
        begin
            c = random_cell();
            if (i == count - 1)
                c.last = 1'b1;
            send_cell(c);
        end
        settle();
    endtask

    task automatic run_directed();
        cell_t c;
        // quiet cell over every link: zero force
        c = '0;
        c.mask = 8'hFF;
        c.last = 1'b1;
        send_cell(c);
        // one link at a time, paired per result
        for (int k = 0; k < 8; k++)
        begin
            c = '0;
            c.pdf[k + 1] = k[0] ? 16'(-(k + 1) * 3000) : 16'((k + 1) * 3000);
            c.mask = 8'd1 << k;
            c.last = k[0];
            send_cell(c);
        end
        // zero density: reciprocal pinned to its largest value
        c = '0;
        c.pdf[0] = 16'h8000;
        c.pdf[1] = 16'sd16384;
        c.pdf[2] = -16'sd16384;
        c.mask = 8'b0000_0011;
        c.last = 1'b1;
        send_cell(c);
        // density of plus one, then minus one count
        c = '0;
        c.pdf[0] = 16'h8000;
        c.pdf[1] = 16'sd1;
        c.mask = 8'b0000_0001;
        send_cell(c);
        c.pdf[1] = -16'sd1;
        c.last = 1'b1;
        send_cell(c);
        // most negative density
        c = '0;
        for (int k = 0; k < 9; k++)
            c.pdf[k] = 16'h8000;
        c.mask = 8'hFF;
        c.last = 1'b1;
        send_cell(c);
        // most positive density over every link, then with no link
        for (int k = 0; k < 9; k++)
            c.pdf[k] = 16'h7FFF;
        send_cell(c);
        c.mask = 8'h00;
        send_cell(c);
        // x sum driven into positive saturation
        c = '0;
        c.pdf[0] = 16'h8000;
        c.pdf[3] = -16'sd32767;
        c.pdf[4] = 16'sd32767;
        c.mask = 8'b0000_1100;
        for (int i = 0; i < 3; i++)
        begin
            c.last = (i == 2);
            send_cell(c);
        end
        // both sums driven into negative saturation
        c = '0;
        c.pdf[0] = 16'h8000;
        c.pdf[1] = -16'sd32767;
        c.pdf[2] = 16'sd32767;
        c.pdf[3] = 16'sd32767;
        c.pdf[4] = -16'sd32767;
        c.mask = 8'b0000_1111;
        for (int i = 0; i < 3; i++)
        begin
            c.last = (i == 2);
            send_cell(c);
        end
        settle();
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        pdf_center    = '0;
        pdf_north     = '0;
        pdf_south     = '0;
        pdf_west      = '0;
        pdf_east      = '0;
        pdf_northwest = '0;
        pdf_northeast = '0;
        pdf_southwest = '0;
        pdf_southeast = '0;
        link_mask     = '0;
        last_cell     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed cells under the reset scale of 1.0
        run_directed();

        // random phases across the scale range
        write_scale(24'hFF_FFFF);
        run_phase(180);
        write_scale(24'd0);
        run_phase(150);
        write_scale(24'($urandom_range(0, 24'hFF_FFFF)));
        run_phase(200);
        write_scale(24'd1);
        run_phase(120);
        write_scale(24'($urandom_range(32768, 262143)));
        run_phase(200);

        // final phase with no stalls on either side
        calm = 1'b1;
        write_scale(24'($urandom_range(49152, 131071)));
        run_phase(150);

        $display("covered %0d boundary cells and %0d drag/lift results", board.cells,
                 board.results);
        $display("across %0d scale settings, with saturation and zero density",
                 scale_writes + 1);
        if (board.errors == 0)
            $display("lattice_boundary_force_accumulator_test: PASS");
        else
            $display("lattice_boundary_force_accumulator_test: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/lbfa_pkg.sv
src/lbfa_recip.sv
src/lattice_boundary_force_accumulator.sv
tb/lattice_boundary_force_accumulator_test.sv
